/* rtl/double_hash_record_table_macros.svh */
// Assertion macros shared by the record table RTL.
// Used by files that include this header; needs clk and rst in the including scope.
`ifndef DOUBLE_HASH_RECORD_TABLE_MACROS_SVH
`define DOUBLE_HASH_RECORD_TABLE_MACROS_SVH

`ifndef NO_ASSERTIONS

`define DHRT_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed in %m");

`define DHRT_ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (rst) pre |=> post) \
    else $error("assertion failed in %m");

`else

`define DHRT_ASSERT(lbl, prop)

`define DHRT_ASSERT_NEXT(lbl, pre, post)

`endif

`endif

/* rtl/dhrt_pkg.sv */
// Types and constants for the double hashing record table.
// Used by dhrt_div and double_hash_record_table; depends on nothing.
package dhrt_pkg;

  localparam int CMD_W      = 2;
  localparam int KEY_W      = 31;
  localparam int SCORE_W    = 5;
  localparam int PAY_W      = 64;
  localparam int STATUS_W   = 3;
  localparam int SIZE_W     = 11;
  localparam int PRIME_W    = 10;
  localparam int CNT_W      = 11;
  localparam int DIV_CNT_W  = 5;
  localparam int IN_W       = 104;
  localparam int OUT_W      = 128;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 11;

  localparam logic [CMD_W-1:0] CMD_INSERT  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_ADD     = 2'd1;
  localparam logic [CMD_W-1:0] CMD_REPLACE = 2'd2;
  localparam logic [CMD_W-1:0] CMD_LOOKUP  = 2'd3;

  localparam logic [STATUS_W-1:0] STATUS_OK        = 3'd0;
  localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 3'd1;
  localparam logic [STATUS_W-1:0] STATUS_EXCEEDED  = 3'd2;
  localparam logic [STATUS_W-1:0] STATUS_FULL      = 3'd3;
  localparam logic [STATUS_W-1:0] STATUS_BAD_KEY   = 3'd4;

  localparam logic [CFG_IDX_W-1:0] REG_TABLE_SIZE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_PRIME = 1'd1;

  localparam logic [SIZE_W-1:0]  RESET_TABLE_SIZE = 11'd1021;
  localparam logic [PRIME_W-1:0] RESET_STEP_PRIME = 10'd1019;

  typedef struct packed {
    logic [1:0]         pad;
    logic [PAY_W-1:0]   payload;
    logic [SCORE_W-1:0] score_delta;
    logic [KEY_W-1:0]   key;
    logic [CMD_W-1:0]   command;
  } in_item_t;

  typedef struct packed {
    logic [2:0]          pad;
    logic [CNT_W-1:0]    member_count;
    logic [PAY_W-1:0]    found_payload;
    logic [SCORE_W-1:0]  found_score;
    logic [KEY_W-1:0]    found_key;
    logic [SIZE_W-1:0]   probe_count;
    logic [STATUS_W-1:0] status;
  } out_item_t;

  typedef struct packed {
    logic [KEY_W-1:0]   key;
    logic [SCORE_W-1:0] score;
    logic [PAY_W-1:0]   payload;
  } entry_t;

  typedef struct packed {
    logic                 start;
    logic [KEY_W-1:0]     dividend;
    logic [SIZE_W-1:0]    divisor;
    logic [DIV_CNT_W-1:0] nbits;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [SIZE_W-1:0] rem;
  } div_rsp_t;

endpackage

/* rtl/dhrt_div.sv */
// Shared restoring remainder unit, one dividend bit per cycle, MSB first.
// Depends on dhrt_pkg for the request and response types.
module dhrt_div (
  input  logic               clk,
  input  logic               rst,
  input  dhrt_pkg::div_req_t req,
  output dhrt_pkg::div_rsp_t rsp
);
  import dhrt_pkg::*;

  logic                 busy;
  logic                 done;
  logic [DIV_CNT_W-1:0] cnt;
  logic [KEY_W-1:0]     dvd;
  logic [SIZE_W-1:0]    dvs;
  logic [SIZE_W-1:0]    rem;
  logic [SIZE_W:0]      trial;
  logic [SIZE_W:0]      dvs_ext;

  assign trial   = {rem, dvd[KEY_W-1]};
  assign dvs_ext = {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= req.nbits;
      end else if (busy) begin
        if (cnt == DIV_CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
        cnt <= cnt - DIV_CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      dvd <= req.dividend;
      dvs <= req.divisor;
      rem <= '0;
    end else if (busy) begin
      dvd <= {dvd[KEY_W-2:0], 1'b0};
      if (trial >= dvs_ext) begin
        rem <= SIZE_W'(trial - dvs_ext);
      end else begin
        rem <= trial[SIZE_W-1:0];
      end
    end
  end

  assign rsp.done = done;
  assign rsp.rem  = rem;

endmodule

/* rtl/double_hash_record_table.sv */
// After reset the block clears the slot memory, one slot per cycle, and takes no item until
// that is done. The start slot, the step and the step reduced by the table size come from
// one shared remainder unit that retires one dividend bit per cycle (31, 31 and 10 bits).
// Each probe is one registered read of the slot memory followed by a compare.
// A key of zero is answered without divisions or probes. Configuration writes are taken
// in any cycle.
`include "double_hash_record_table_macros.svh"
// Top level: sequencer, slot memory, configuration registers and result register.
// Depends on dhrt_pkg and dhrt_div.
module double_hash_record_table #(
  parameter int CAPACITY    = 1024,
  parameter int SCORE_LIMIT = 24
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // command, key, score_delta, payload, zero fill
  input  logic [dhrt_pkg::IN_W-1:0]         s_axis_tdata,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // status, probe_count, found_key, found_score, found_payload, member_count, zero fill
  output logic [dhrt_pkg::OUT_W-1:0]        m_axis_tdata,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [dhrt_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [dhrt_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import dhrt_pkg::*;

  localparam int AW = $clog2(CAPACITY);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_DIV1  = 3'd2;
  localparam logic [2:0] S_DIV2  = 3'd3;
  localparam logic [2:0] S_DIV3  = 3'd4;
  localparam logic [2:0] S_RD    = 3'd5;
  localparam logic [2:0] S_CHK   = 3'd6;
  localparam logic [2:0] S_OUT   = 3'd7;

  logic [2:0]          state;
  logic [SIZE_W-1:0]   table_size;
  logic [PRIME_W-1:0]  step_prime;
  logic [AW-1:0]       clr_addr;
  logic [CNT_W-1:0]    stored_count;

  in_item_t            in_item;
  logic                accept;
  logic [CMD_W-1:0]    cmd_r;
  logic [KEY_W-1:0]    key_r;
  logic [SCORE_W-1:0]  delta_r;
  logic [PAY_W-1:0]    payload_r;

  logic [SIZE_W-1:0]   n_eff;
  logic [SIZE_W-1:0]   n_reg;
  logic [PRIME_W-1:0]  q_eff;
  logic [PRIME_W-1:0]  q_reg;
  logic [PRIME_W-1:0]  step_val;

  logic [SIZE_W-1:0]   pos;
  logic [SIZE_W-1:0]   stepm;
  logic [SIZE_W-1:0]   probes;
  logic [SIZE_W-1:0]   probes_inc;
  logic [SIZE_W:0]     pos_adv;
  logic [SIZE_W-1:0]   pos_wrap;

  logic [STATUS_W-1:0] res_status;
  logic [SIZE_W-1:0]   res_probes;
  logic [KEY_W-1:0]    res_fkey;
  logic [SCORE_W-1:0]  res_fscore;
  logic [PAY_W-1:0]    res_fpay;
  out_item_t           out_item;

  entry_t              mem [CAPACITY];
  entry_t              rd_data;
  entry_t              wr_data;
  logic                wr_en;
  logic [AW-1:0]       wr_addr;

  logic                hit;
  logic                slot_empty;
  logic [SCORE_W:0]    score_sum;
  logic                exceed;

  div_req_t            div_req;
  div_rsp_t            div_rsp;

  dhrt_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  assign in_item       = in_item_t'(s_axis_tdata);
  assign s_axis_tready = (state == S_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign cfg_ready     = 1'b1;

  always_comb begin
    if (table_size < SIZE_W'(2)) begin
      n_eff = SIZE_W'(2);
    end else if (int'(table_size) > CAPACITY) begin
      n_eff = SIZE_W'(CAPACITY);
    end else begin
      n_eff = table_size;
    end
  end

  assign q_eff    = (step_prime == '0) ? PRIME_W'(1) : step_prime;
  assign step_val = q_reg - div_rsp.rem[PRIME_W-1:0];

  always_comb begin
    div_req.start    = 1'b0;
    div_req.dividend = key_r;
    div_req.divisor  = n_reg;
    div_req.nbits    = DIV_CNT_W'(KEY_W);
    case (state)
      S_IDLE: begin
        div_req.start    = accept && (in_item.key != '0);
        div_req.dividend = in_item.key;
        div_req.divisor  = n_eff;
      end
      S_DIV1: begin
        div_req.start   = div_rsp.done;
        div_req.divisor = SIZE_W'(q_reg);
      end
      S_DIV2: begin
        div_req.start    = div_rsp.done;
        div_req.dividend = {step_val, {(KEY_W-PRIME_W){1'b0}}};
        div_req.nbits    = DIV_CNT_W'(PRIME_W);
      end
      default: begin
      end
    endcase
  end

  assign probes_inc = probes + SIZE_W'(1);
  assign pos_adv    = {1'b0, pos} + {1'b0, stepm};
  assign pos_wrap   = (pos_adv >= {1'b0, n_reg}) ? SIZE_W'(pos_adv - {1'b0, n_reg})
                                                 : pos_adv[SIZE_W-1:0];
  assign slot_empty = (rd_data.key == '0);
  assign hit        = slot_empty || ((cmd_r != CMD_INSERT) && (rd_data.key == key_r));
  assign score_sum  = {1'b0, rd_data.score} + {1'b0, delta_r};
  assign exceed     = int'(score_sum) > SCORE_LIMIT;

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = AW'(pos);
    wr_data = rd_data;
    if (state == S_CLEAR) begin
      wr_en   = 1'b1;
      wr_addr = clr_addr;
      wr_data = '0;
    end else if ((state == S_CHK) && hit) begin
      if (cmd_r == CMD_INSERT) begin
        wr_en           = 1'b1;
        wr_data.key     = key_r;
        wr_data.score   = '0;
        wr_data.payload = payload_r;
      end else if (!slot_empty && (cmd_r == CMD_ADD) && !exceed) begin
        wr_en         = 1'b1;
        wr_data.score = score_sum[SCORE_W-1:0];
      end else if (!slot_empty && (cmd_r == CMD_REPLACE)) begin
        wr_en           = 1'b1;
        wr_data.payload = payload_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_RD) begin
      rd_data <= mem[AW'(pos)];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      table_size <= RESET_TABLE_SIZE;
      step_prime <= RESET_STEP_PRIME;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_TABLE_SIZE: table_size <= cfg_data;
        REG_STEP_PRIME: step_prime <= cfg_data[PRIME_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    out_item               = '0;
    out_item.status        = res_status;
    out_item.probe_count   = res_probes;
    out_item.found_key     = res_fkey;
    out_item.found_score   = res_fscore;
    out_item.found_payload = res_fpay;
    out_item.member_count  = stored_count;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_CLEAR;
      clr_addr      <= '0;
      stored_count  <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready && (state != S_OUT)) begin
        m_axis_tvalid <= 1'b0;
      end
      case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + AW'(1);
          if (clr_addr == AW'(CAPACITY - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            if (in_item.key == '0) begin
              state <= S_OUT;
            end else begin
              state <= S_DIV1;
            end
          end
        end
        S_DIV1: begin
          if (div_rsp.done) begin
            state <= S_DIV2;
          end
        end
        S_DIV2: begin
          if (div_rsp.done) begin
            state <= S_DIV3;
          end
        end
        S_DIV3: begin
          if (div_rsp.done) begin
            state <= S_RD;
          end
        end
        S_RD: begin
          state <= S_CHK;
        end
        S_CHK: begin
          if (hit) begin
            if (cmd_r == CMD_INSERT) begin
              stored_count <= stored_count + CNT_W'(1);
            end
            state <= S_OUT;
          end else if (probes_inc == n_reg) begin
            state <= S_OUT;
          end else begin
            state <= S_RD;
          end
        end
        S_OUT: begin
          if (!m_axis_tvalid || m_axis_tready) begin
            m_axis_tvalid <= 1'b1;
            state         <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (accept) begin
          cmd_r      <= in_item.command;
          key_r      <= in_item.key;
          delta_r    <= in_item.score_delta;
          payload_r  <= in_item.payload;
          n_reg      <= n_eff;
          q_reg      <= q_eff;
          res_status <= (in_item.key == '0) ? STATUS_BAD_KEY : STATUS_OK;
          res_probes <= '0;
          res_fkey   <= '0;
          res_fscore <= '0;
          res_fpay   <= '0;
        end
      end
      S_DIV1: begin
        if (div_rsp.done) begin
          pos <= div_rsp.rem;
        end
      end
      S_DIV3: begin
        if (div_rsp.done) begin
          stepm  <= div_rsp.rem;
          probes <= '0;
        end
      end
      S_CHK: begin
        if (hit) begin
          res_probes <= probes_inc;
          if (cmd_r == CMD_INSERT) begin
            res_status <= STATUS_OK;
          end else if (slot_empty) begin
            res_status <= STATUS_NOT_FOUND;
          end else begin
            case (cmd_r)
              CMD_ADD: begin
                if (exceed) begin
                  res_status <= STATUS_EXCEEDED;
                  res_fscore <= rd_data.score;
                end else begin
                  res_status <= STATUS_OK;
                  res_fscore <= score_sum[SCORE_W-1:0];
                end
              end
              CMD_REPLACE: begin
                res_fscore <= rd_data.score;
              end
              CMD_LOOKUP: begin
                res_fkey   <= rd_data.key;
                res_fscore <= rd_data.score;
                res_fpay   <= rd_data.payload;
              end
              default: begin
              end
            endcase
          end
        end else if (probes_inc == n_reg) begin
          res_probes <= n_reg;
          res_status <= (cmd_r == CMD_INSERT) ? STATUS_FULL : STATUS_NOT_FOUND;
        end else begin
          pos    <= pos_wrap;
          probes <= probes_inc;
        end
      end
      S_OUT: begin
        if (!m_axis_tvalid || m_axis_tready) begin
          m_axis_tdata <= OUT_W'(out_item);
        end
      end
      default: begin
      end
    endcase
  end

  `DHRT_ASSERT(a_pos_in_range, (state == S_RD) |-> (pos < n_reg))
  `DHRT_ASSERT(a_probe_bound, (state == S_CHK) |-> (probes < n_reg))
  `DHRT_ASSERT(a_div_done_expected, div_rsp.done |-> (state >= S_DIV1 && state <= S_DIV3))
  `DHRT_ASSERT_NEXT(a_count_only_on_insert, (state != S_CHK), $stable(stored_count))

endmodule

/* tb/sv/double_hash_record_table_test.sv */
// Self-checking test of the double hashing record table over its item streams.
// Needs dhrt_pkg and double_hash_record_table; a built-in table model predicts each reply.
module double_hash_record_table_test;
  timeunit 1ns;
  timeprecision 1ps;
  import dhrt_pkg::*;

  localparam int          SLOTS       = 1024;
  localparam int          SCORE_CAP   = 24;
  localparam int unsigned CYCLE_LIMIT = 4_000_000;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_W-1:0]       s_axis_tdata = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_W-1:0]      m_axis_tdata;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  double_hash_record_table #(
    .CAPACITY(SLOTS),
    .SCORE_LIMIT(SCORE_CAP)
  ) dut (
    .clk(clk),
    .rst(rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Model of the table contents and settings.
  logic [KEY_W-1:0]   key_mem [SLOTS];
  logic [SCORE_W-1:0] score_mem [SLOTS];
  logic [PAY_W-1:0]   payload_mem [SLOTS];
  int unsigned        member_total = 0;
  logic [SIZE_W-1:0]  size_setting = RESET_TABLE_SIZE;
  logic [PRIME_W-1:0] prime_setting = RESET_STEP_PRIME;

  in_item_t         queued_commands [$];
  out_item_t        expected_replies [$];
  logic [KEY_W-1:0] known_keys [$];

  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  bit          in_taken = 1'b0;
  int unsigned mismatches = 0;
  int unsigned replies_checked = 0;
  int unsigned cycles = 0;
  int unsigned status_seen [8];

  initial begin
    foreach (key_mem[i]) key_mem[i] = '0;
    foreach (status_seen[i]) status_seen[i] = 0;
  end

  function automatic out_item_t apply_command(in_item_t it);
    out_item_t   r;
    int unsigned n, q, pos, step, slot, probes, sum, i;
    bit          hit;
    r = '0;
    n = size_setting;
    if (n < 2) n = 2;
    if (n > SLOTS) n = SLOTS;
    q = (prime_setting == 0) ? 1 : prime_setting;
    if (it.key == 0) begin
      r.status = STATUS_BAD_KEY;
    end else begin
      pos = it.key % n;
      step = q - (it.key % q);
      hit = 1'b0;
      slot = 0;
      probes = n;
      for (i = 0; i < n && !hit; i++) begin
        if (key_mem[pos] == 0 || (it.command != CMD_INSERT && key_mem[pos] == it.key)) begin
          hit = 1'b1;
          slot = pos;
          probes = i + 1;
        end else begin
          pos = (pos + step) % n;
        end
      end
      r.probe_count = SIZE_W'(probes);
      if (it.command == CMD_INSERT) begin
        if (hit) begin
          key_mem[slot] = it.key;
          score_mem[slot] = '0;
          payload_mem[slot] = it.payload;
          member_total++;
        end else begin
          r.status = STATUS_FULL;
        end
      end else if (!hit || key_mem[slot] == 0) begin
        r.status = STATUS_NOT_FOUND;
      end else begin
        case (it.command)
          CMD_ADD: begin
            sum = score_mem[slot] + it.score_delta;
            if (sum > SCORE_CAP) r.status = STATUS_EXCEEDED;
            else score_mem[slot] = sum[SCORE_W-1:0];
          end
          CMD_REPLACE: begin
            payload_mem[slot] = it.payload;
          end
          default: begin
            r.found_key = key_mem[slot];
            r.found_payload = payload_mem[slot];
          end
        endcase
        r.found_score = score_mem[slot];
      end
    end
    r.member_count = member_total[CNT_W-1:0];
    return r;
  endfunction

  function automatic logic [KEY_W-1:0] fresh_key();
    if ($urandom_range(1)) return KEY_W'($urandom_range(4000, 1));
    return KEY_W'($urandom());
  endfunction

  // Inserts of fresh keys mixed with work on recently inserted keys, with some noise.
  function automatic in_item_t random_command();
    in_item_t    it;
    int unsigned pick, depth;
    it = '0;
    pick = $urandom_range(99);
    it.payload = {$urandom(), $urandom()};
    if ($urandom_range(19) == 0) it.payload = $urandom_range(1) ? {PAY_W{1'b1}} : '0;
    if ($urandom_range(9) == 0) it.score_delta = SCORE_W'($urandom_range(31, 25));
    else it.score_delta = SCORE_W'($urandom_range(12));
    if (known_keys.size() != 0) begin
      depth = (known_keys.size() > 32) ? 31 : known_keys.size() - 1;
      it.key = known_keys[known_keys.size() - 1 - $urandom_range(depth)];
    end else begin
      it.key = fresh_key();
    end
    if (pick < 4) begin
      it.command = CMD_W'($urandom_range(3));
      it.key = '0;
    end else if (pick < 34) begin
      it.command = CMD_INSERT;
      it.key = fresh_key();
      known_keys.push_back(it.key);
    end else if (pick < 42) begin
      it.command = CMD_INSERT;
    end else if (pick < 64) begin
      it.command = CMD_ADD;
    end else if (pick < 74) begin
      it.command = CMD_REPLACE;
    end else if (pick < 94) begin
      it.command = CMD_LOOKUP;
    end else begin
      it.command = CMD_W'($urandom_range(3));
      it.key = fresh_key();
    end
    return it;
  endfunction

  task automatic add_command(input logic [CMD_W-1:0] cmd, input logic [KEY_W-1:0] key,
                             input logic [SCORE_W-1:0] delta, input logic [PAY_W-1:0] payload);
    in_item_t it;
    it = '0;
    it.command = cmd;
    it.key = key;
    it.score_delta = delta;
    it.payload = payload;
    queued_commands.push_back(it);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == REG_TABLE_SIZE) size_setting = val;
    else prime_setting = val[PRIME_W-1:0];
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic wait_idle();
    do @(posedge clk);
    while (queued_commands.size() != 0 || s_axis_tvalid || expected_replies.size() != 0);
  endtask

  // Command driver.
  always @(posedge clk) begin
    in_taken = s_axis_tvalid && s_axis_tready;
    if (!rst && in_taken) expected_replies.push_back(apply_command(s_axis_tdata));
  end

  always @(negedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || in_taken) begin
      if (queued_commands.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= queued_commands.pop_front();
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Reply monitor.
  always @(negedge clk) begin
    m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin : check_replies
    out_item_t got, want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata;
      status_seen[got.status]++;
      if (expected_replies.size() == 0) begin
        $error("reply with no command outstanding: %h", m_axis_tdata);
        mismatches++;
      end else begin
        want = expected_replies.pop_front();
        replies_checked++;
        if (got.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, got.status);
          mismatches++;
        end
        if (got.probe_count !== want.probe_count) begin
          $error("probe_count: expected %0d, got %0d", want.probe_count, got.probe_count);
          mismatches++;
        end
        if (got.found_key !== want.found_key) begin
          $error("found_key: expected %0d, got %0d", want.found_key, got.found_key);
          mismatches++;
        end
        if (got.found_score !== want.found_score) begin
          $error("found_score: expected %0d, got %0d", want.found_score, got.found_score);
          mismatches++;
        end
        if (got.found_payload !== want.found_payload) begin
          $error("found_payload: expected %h, got %h", want.found_payload, got.found_payload);
          mismatches++;
        end
        if (got.member_count !== want.member_count) begin
          $error("member_count: expected %0d, got %0d", want.member_count, got.member_count);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles == CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin : stimulus
    int unsigned sizes [7]  = '{13, 2047, 64, 7, 1021, 200, 2};
    int unsigned primes [7] = '{11, 1023, 61, 5, 1019, 7, 1};
    int unsigned sends [7]  = '{0, 56, 0, 9, 56, 0, 9};
    int unsigned stalls [7] = '{0, 0, 56, 9, 0, 56, 9};
    int unsigned counts [7] = '{150, 150, 150, 100, 150, 150, 100};
    int unsigned p;

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Settings after reset.
    add_command(CMD_INSERT, '0, '0, {PAY_W{1'b1}});
    add_command(CMD_ADD, '0, 5'd3, '0);
    add_command(CMD_REPLACE, '0, '0, 64'h1);
    add_command(CMD_LOOKUP, '0, '0, '0);
    add_command(CMD_INSERT, 31'd5, '0, {PAY_W{1'b1}});
    add_command(CMD_LOOKUP, 31'd5, '0, '0);
    add_command(CMD_ADD, 31'd5, 5'd24, '0);
    add_command(CMD_ADD, 31'd5, 5'd1, '0);
    add_command(CMD_REPLACE, 31'd5, '0, '0);
    add_command(CMD_LOOKUP, 31'd5, '0, '0);
    add_command(CMD_INSERT, 31'd1026, '0, 64'h0123_4567_89AB_CDEF);
    add_command(CMD_LOOKUP, 31'd1026, '0, '0);
    add_command(CMD_INSERT, 31'd5, '0, 64'h8000_0000_0000_0001);
    add_command(CMD_ADD, {KEY_W{1'b1}}, 5'd31, '0);
    add_command(CMD_INSERT, {KEY_W{1'b1}}, '0, 64'hFEDC_BA98_7654_3210);
    add_command(CMD_ADD, {KEY_W{1'b1}}, 5'd31, '0);
    add_command(CMD_ADD, {KEY_W{1'b1}}, 5'd0, '0);
    wait_idle();

    // Size below range and zero step: two slots, linear walk, filled up.
    write_reg(REG_TABLE_SIZE, 11'd1);
    write_reg(REG_STEP_PRIME, 11'd0);
    add_command(CMD_INSERT, 31'd2, '0, 64'hAAAA_5555_AAAA_5555);
    add_command(CMD_INSERT, 31'd3, '0, 64'h5555_AAAA_5555_AAAA);
    add_command(CMD_INSERT, 31'd4, '0, '0);
    add_command(CMD_LOOKUP, 31'd9, '0, '0);
    add_command(CMD_LOOKUP, 31'd3, '0, '0);
    add_command(CMD_REPLACE, 31'd3, '0, {PAY_W{1'b1}});
    wait_idle();

    for (p = 0; p < 7; p++) begin
      write_reg(REG_TABLE_SIZE, CFG_DATA_W'(sizes[p]));
      write_reg(REG_STEP_PRIME, CFG_DATA_W'(primes[p]));
      send_idle_pct = sends[p];
      recv_stall_pct = stalls[p];
      repeat (counts[p]) queued_commands.push_back(random_command());
      wait_idle();
    end

    repeat (300) @(posedge clk);
    $display("Checked %0d replies over nine table settings, with and without stalls.",
             replies_checked);
    $display("Replies: ok %0d, not found %0d, score capped %0d, full %0d, zero key %0d.",
             status_seen[STATUS_OK], status_seen[STATUS_NOT_FOUND],
             status_seen[STATUS_EXCEEDED], status_seen[STATUS_FULL],
             status_seen[STATUS_BAD_KEY]);
    if (mismatches == 0 && expected_replies.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
